### hdl/cbe_pkg.sv
// Shared types for the cubic Bezier easing block: states, operand selects, command and status.
package cbe_pkg;

    typedef enum logic [4:0] {
        S_IDLE,
        S_F0,
        S_F1,
        S_F2,
        S_F3,
        S_F4,
        S_F5,
        S_F6,
        S_CHK,
        S_Y0,
        S_Y1,
        S_Y2,
        S_Y3,
        S_Y4,
        S_Y5,
        S_Y6,
        S_Y7,
        S_DONE
    } t_state;

    typedef enum logic [2:0] {
        OPA_K0,
        OPA_K1,
        OPA_K2,
        OPA_P,
        OPA_T,
        OPA_R,
        OPA_T2
    } t_opa;

    typedef enum logic [2:0] {
        OPB_T,
        OPB_R,
        OPB_R2,
        OPB_C1Y3,
        OPB_C2Y3
    } t_opb;

    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_LOAD,
        ACC_ADD,
        ACC_ADD_SUB_X
    } t_acc_op;

    typedef struct packed {
        logic    load;
        t_opa    mul_a;
        t_opb    mul_b;
        t_acc_op acc_op;
        logic    save_t2;
        logic    save_r2;
        logic    load_r;
        logic    step_t;
        logic    finish;
    } t_dp_cmd;

    typedef struct packed {
        logic linear_in;
        logic near_root;
    } t_dp_status;

endpackage

### hdl/cbe_datapath.sv
// Datapath of the easing block: operand registers, shared multiplier, accumulator, saturation.
module cbe_datapath #(
    parameter int FRACTION_BITS = 16
) (
    input  logic                i_clk,
    input  cbe_pkg::t_dp_cmd    i_cmd,
    input  logic [16:0]         i_x_frac,
    input  logic [6:0]          i_ctrl1_x,
    input  logic [6:0]          i_ctrl1_y,
    input  logic [6:0]          i_ctrl2_x,
    input  logic [6:0]          i_ctrl2_y,
    output cbe_pkg::t_dp_status o_status,
    output logic [16:0]         o_y_frac,
    output logic                o_clipped
);

    localparam int MW = FRACTION_BITS + 8;
    localparam int AW = FRACTION_BITS + 12;
    localparam int PW = 2 * MW;

    localparam logic signed [MW-1:0] ONE_M = MW'(1) << FRACTION_BITS;
    localparam logic signed [AW-1:0] ONE_A = AW'(1) << FRACTION_BITS;
    localparam logic signed [AW-1:0] T_MAX = ONE_A <<< 2;
    localparam logic signed [AW-1:0] T_MIN = -T_MAX;
    localparam logic signed [AW-1:0] EPS   = AW'((33 << FRACTION_BITS) >> 16);

    function automatic logic signed [MW-1:0] coord(input logic [6:0] code);
        logic [MW-1:0] res;
        logic [2:0]    k;
        res = '0;
        k   = 3'd6;
        for (int j = FRACTION_BITS - 1; j >= 0; j--) begin
            res[j] = code[k];
            k      = (k == 3'd0) ? 3'd6 : k - 3'd1;
        end
        if (code == 7'd127) begin
            res = ONE_M;
        end
        return $signed(res);
    endfunction

    logic signed [MW-1:0] r_k0, r_k1, r_k2, r_c1y3, r_c2y3;
    logic signed [MW-1:0] r_t, r_r, r_t2, r_r2;
    logic signed [AW-1:0] r_x, r_p, r_acc;
    logic                 r_linear;
    logic [16:0]          r_y;
    logic                 r_clip;

    logic signed [MW-1:0] w_c1x, w_c1y, w_c2x, w_c2y;
    logic signed [MW-1:0] w_c1x3, w_c2x3;
    logic signed [AW-1:0] w_xin, w_x;
    logic signed [MW-1:0] w_a, w_b;
    logic signed [PW-1:0] w_prod;
    logic signed [AW-1:0] w_fl;
    logic signed [MW-1:0] w_p_op;
    logic signed [AW-1:0] w_tn;

    assign w_c1x  = coord(i_ctrl1_x);
    assign w_c1y  = coord(i_ctrl1_y);
    assign w_c2x  = coord(i_ctrl2_x);
    assign w_c2y  = coord(i_ctrl2_y);
    assign w_c1x3 = (w_c1x <<< 1) + w_c1x;
    assign w_c2x3 = (w_c2x <<< 1) + w_c2x;
    assign w_xin  = $signed({{(AW - 17){1'b0}}, i_x_frac});
    assign w_x    = (w_xin > ONE_A) ? ONE_A : w_xin;

    assign w_p_op = r_p[MW-1:0];

    always_comb begin
        unique case (i_cmd.mul_a)
            cbe_pkg::OPA_K0: w_a = r_k0;
            cbe_pkg::OPA_K1: w_a = r_k1;
            cbe_pkg::OPA_K2: w_a = r_k2;
            cbe_pkg::OPA_P:  w_a = w_p_op;
            cbe_pkg::OPA_T:  w_a = r_t;
            cbe_pkg::OPA_R:  w_a = r_r;
            cbe_pkg::OPA_T2: w_a = r_t2;
            default:         w_a = r_t;
        endcase
        unique case (i_cmd.mul_b)
            cbe_pkg::OPB_T:    w_b = r_t;
            cbe_pkg::OPB_R:    w_b = r_r;
            cbe_pkg::OPB_R2:   w_b = r_r2;
            cbe_pkg::OPB_C1Y3: w_b = r_c1y3;
            cbe_pkg::OPB_C2Y3: w_b = r_c2y3;
            default:           w_b = r_t;
        endcase
    end

    assign w_prod = w_a * w_b;
    assign w_fl   = $signed(w_prod[FRACTION_BITS+AW-1:FRACTION_BITS]);

    always_comb begin
        w_tn = $signed({{(AW - MW){r_t[MW-1]}}, r_t}) - (r_acc >>> 1);
        if (w_tn > T_MAX) begin
            w_tn = T_MAX;
        end else if (w_tn < T_MIN) begin
            w_tn = T_MIN;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p <= w_fl;
        if (i_cmd.load) begin
            r_x      <= w_x;
            r_t      <= w_x[MW-1:0];
            r_k0     <= ONE_M + w_c1x3 - w_c2x3;
            r_k1     <= w_c2x3 - (w_c1x3 <<< 1);
            r_k2     <= w_c1x3;
            r_c1y3   <= (w_c1y <<< 1) + w_c1y;
            r_c2y3   <= (w_c2y <<< 1) + w_c2y;
            r_linear <= o_status.linear_in;
        end else if (i_cmd.step_t) begin
            r_t <= w_tn[MW-1:0];
        end
        unique case (i_cmd.acc_op)
            cbe_pkg::ACC_HOLD:      r_acc <= r_acc;
            cbe_pkg::ACC_LOAD:      r_acc <= r_p;
            cbe_pkg::ACC_ADD:       r_acc <= r_acc + r_p;
            cbe_pkg::ACC_ADD_SUB_X: r_acc <= r_acc + r_p - r_x;
            default:                r_acc <= r_acc;
        endcase
        if (i_cmd.load_r) begin
            r_r <= ONE_M - r_t;
        end
        if (i_cmd.save_t2) begin
            r_t2 <= w_p_op;
        end
        if (i_cmd.save_r2) begin
            r_r2 <= w_p_op;
        end
        if (i_cmd.finish) begin
            if (r_linear) begin
                r_y    <= r_x[16:0];
                r_clip <= 1'b0;
            end else if (r_acc < 0) begin
                r_y    <= '0;
                r_clip <= 1'b1;
            end else if (r_acc > ONE_A) begin
                r_y    <= ONE_A[16:0];
                r_clip <= 1'b1;
            end else begin
                r_y    <= r_acc[16:0];
                r_clip <= 1'b0;
            end
        end
    end

    assign o_status.linear_in = (i_ctrl1_x == i_ctrl1_y) && (i_ctrl2_x == i_ctrl2_y);
    assign o_status.near_root = (r_acc < EPS) && (r_acc > -EPS);
    assign o_y_frac           = r_y;
    assign o_clipped          = r_clip;

endmodule

### hdl/cbe_ctrl.sv
// Controller of the easing block: sequencing of the Newton steps and the y evaluation.
module cbe_ctrl #(
    parameter int MAX_ITERATIONS = 12
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_valid,
    input  logic                i_m_ready,
    input  cbe_pkg::t_dp_status i_status,
    output cbe_pkg::t_dp_cmd    o_cmd,
    output logic                o_s_ready,
    output logic                o_m_valid
);

    localparam int CW = (MAX_ITERATIONS > 1) ? $clog2(MAX_ITERATIONS) : 1;
    localparam logic [CW-1:0] CNT_LAST = CW'(MAX_ITERATIONS - 1);

    cbe_pkg::t_state r_state, n_state;
    logic [CW-1:0]   r_cnt, n_cnt;
    logic            r_m_valid, n_m_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= cbe_pkg::S_IDLE;
            r_cnt     <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cnt     <= n_cnt;
            r_m_valid <= n_m_valid;
        end
    end

    always_comb begin
        n_state      = r_state;
        n_cnt        = r_cnt;
        o_cmd        = '0;
        o_cmd.mul_a  = cbe_pkg::OPA_T;
        o_cmd.mul_b  = cbe_pkg::OPB_T;
        o_cmd.acc_op = cbe_pkg::ACC_HOLD;
        o_s_ready    = 1'b0;
        unique case (r_state)
            cbe_pkg::S_IDLE: begin
                o_s_ready = 1'b1;
                if (i_s_valid) begin
                    o_cmd.load = 1'b1;
                    n_cnt      = '0;
                    n_state    = i_status.linear_in ? cbe_pkg::S_DONE : cbe_pkg::S_F0;
                end
            end
            cbe_pkg::S_F0: begin
                o_cmd.mul_a = cbe_pkg::OPA_K0;
                n_state     = cbe_pkg::S_F1;
            end
            cbe_pkg::S_F1: begin
                o_cmd.mul_a = cbe_pkg::OPA_P;
                n_state     = cbe_pkg::S_F2;
            end
            cbe_pkg::S_F2: begin
                o_cmd.mul_a = cbe_pkg::OPA_P;
                n_state     = cbe_pkg::S_F3;
            end
            cbe_pkg::S_F3: begin
                o_cmd.acc_op = cbe_pkg::ACC_LOAD;
                o_cmd.mul_a  = cbe_pkg::OPA_K1;
                n_state      = cbe_pkg::S_F4;
            end
            cbe_pkg::S_F4: begin
                o_cmd.mul_a = cbe_pkg::OPA_P;
                n_state     = cbe_pkg::S_F5;
            end
            cbe_pkg::S_F5: begin
                o_cmd.acc_op = cbe_pkg::ACC_ADD;
                o_cmd.mul_a  = cbe_pkg::OPA_K2;
                n_state      = cbe_pkg::S_F6;
            end
            cbe_pkg::S_F6: begin
                o_cmd.acc_op = cbe_pkg::ACC_ADD_SUB_X;
                n_state      = cbe_pkg::S_CHK;
            end
            cbe_pkg::S_CHK: begin
                if (i_status.near_root) begin
                    n_state = cbe_pkg::S_Y0;
                end else begin
                    o_cmd.step_t = 1'b1;
                    if (r_cnt == CNT_LAST) begin
                        n_state = cbe_pkg::S_Y0;
                    end else begin
                        n_cnt   = r_cnt + 1'b1;
                        n_state = cbe_pkg::S_F0;
                    end
                end
            end
            cbe_pkg::S_Y0: begin
                o_cmd.load_r = 1'b1;
                n_state      = cbe_pkg::S_Y1;
            end
            cbe_pkg::S_Y1: begin
                o_cmd.save_t2 = 1'b1;
                o_cmd.mul_a   = cbe_pkg::OPA_R;
                o_cmd.mul_b   = cbe_pkg::OPB_R;
                n_state       = cbe_pkg::S_Y2;
            end
            cbe_pkg::S_Y2: begin
                o_cmd.save_r2 = 1'b1;
                o_cmd.mul_a   = cbe_pkg::OPA_T2;
                n_state       = cbe_pkg::S_Y3;
            end
            cbe_pkg::S_Y3: begin
                o_cmd.acc_op = cbe_pkg::ACC_LOAD;
                o_cmd.mul_a  = cbe_pkg::OPA_T2;
                o_cmd.mul_b  = cbe_pkg::OPB_R;
                n_state      = cbe_pkg::S_Y4;
            end
            cbe_pkg::S_Y4: begin
                o_cmd.mul_a = cbe_pkg::OPA_P;
                o_cmd.mul_b = cbe_pkg::OPB_C2Y3;
                n_state     = cbe_pkg::S_Y5;
            end
            cbe_pkg::S_Y5: begin
                o_cmd.acc_op = cbe_pkg::ACC_ADD;
                o_cmd.mul_b  = cbe_pkg::OPB_R2;
                n_state      = cbe_pkg::S_Y6;
            end
            cbe_pkg::S_Y6: begin
                o_cmd.mul_a = cbe_pkg::OPA_P;
                o_cmd.mul_b = cbe_pkg::OPB_C1Y3;
                n_state     = cbe_pkg::S_Y7;
            end
            cbe_pkg::S_Y7: begin
                o_cmd.acc_op = cbe_pkg::ACC_ADD;
                n_state      = cbe_pkg::S_DONE;
            end
            cbe_pkg::S_DONE: begin
                if (!r_m_valid || i_m_ready) begin
                    o_cmd.finish = 1'b1;
                    n_state      = cbe_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = cbe_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        priority if (o_cmd.finish) begin
            n_m_valid = 1'b1;
        end else if (i_m_ready) begin
            n_m_valid = 1'b0;
        end else begin
            n_m_valid = r_m_valid;
        end
    end

    assign o_m_valid = r_m_valid;

endmodule

### hdl/cubic_bezier_easing.sv
// Top level of the cubic Bezier easing block: stream ports, controller and datapath.
//
//   channel   direction  fields
//   s_axis    in         tdata: x_frac, ctrl1_x, ctrl1_y, ctrl2_x, ctrl2_y
//   m_axis    out        tdata: y_frac   tuser: clipped
//
// A linear curve goes from the request straight to the result; otherwise the block makes n
// passes through the correction loop (1..MAX_ITERATIONS) and then evaluates y.
// The single shared multiplier gives one product per cycle: 6 per pass, 7 for y.
// Reset clears the controller and the output valid; the datapath registers are not reset.
// A result waiting on m_axis stalls only the final write; the next request is taken after it.
module cubic_bezier_easing #(
    parameter int MAX_ITERATIONS = 12,
    parameter int FRACTION_BITS  = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,  // x_frac[16:0], ctrl1_x, ctrl1_y, ctrl2_x, ctrl2_y, pad
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,  // y_frac[16:0], pad
    output logic        m_axis_tuser   // clipped
);

    cbe_pkg::t_dp_cmd    w_cmd;
    cbe_pkg::t_dp_status w_status;
    logic [16:0]         w_y_frac;

    cbe_ctrl #(
        .MAX_ITERATIONS(MAX_ITERATIONS)
    ) u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_s_valid(s_axis_tvalid),
        .i_m_ready(m_axis_tready),
        .i_status (w_status),
        .o_cmd    (w_cmd),
        .o_s_ready(s_axis_tready),
        .o_m_valid(m_axis_tvalid)
    );

    cbe_datapath #(
        .FRACTION_BITS(FRACTION_BITS)
    ) u_datapath (
        .i_clk    (i_clk),
        .i_cmd    (w_cmd),
        .i_x_frac (s_axis_tdata[16:0]),
        .i_ctrl1_x(s_axis_tdata[23:17]),
        .i_ctrl1_y(s_axis_tdata[30:24]),
        .i_ctrl2_x(s_axis_tdata[37:31]),
        .i_ctrl2_y(s_axis_tdata[44:38]),
        .o_status (w_status),
        .o_y_frac (w_y_frac),
        .o_clipped(m_axis_tuser)
    );

    assign m_axis_tdata = {7'b0, w_y_frac};

endmodule

### hdl/cbe_checker.sv
// Port-level checks for the cubic Bezier easing block and their binding.
module cbe_checker #(
    parameter int FRACTION_BITS = 16
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tvalid,
    input logic        i_s_tready,
    input logic        i_m_tvalid,
    input logic        i_m_tready,
    input logic [23:0] i_m_tdata,
    input logic        i_m_tuser
);

    localparam logic [16:0] ONE_M = 17'((64'd1 << FRACTION_BITS) & 64'h1FFFF);

    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !i_m_tvalid)
        else $error("output valid after reset");

    a_busy_after_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && i_s_tready |=> !i_s_tready)
        else $error("input ready right after a request");

    a_result_from_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_m_tvalid) |-> $past(!i_s_tready))
        else $error("result appeared while idle");

    a_clip_at_rail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && i_m_tuser |-> (i_m_tdata[16:0] == 17'd0) || (i_m_tdata[16:0] == ONE_M))
        else $error("clipped result not at a rail");

    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && !i_m_tready |=> i_m_tvalid && $stable(i_m_tdata) && $stable(i_m_tuser))
        else $error("stalled result changed");

endmodule

bind cubic_bezier_easing cbe_checker #(
    .FRACTION_BITS(FRACTION_BITS)
) u_cbe_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .i_s_tvalid(s_axis_tvalid),
    .i_s_tready(s_axis_tready),
    .i_m_tvalid(m_axis_tvalid),
    .i_m_tready(m_axis_tready),
    .i_m_tdata (m_axis_tdata),
    .i_m_tuser (m_axis_tuser)
);
